@@ design/dq_pkg.sv @@
package dq_pkg;

    // operation codes carried on the func field
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dq_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dq_sts;

endpackage

@@ design/double_ended_queue.sv @@
// Bounded double-ended queue of DEPTH elements of DATA_WIDTH bits. Each
// input transaction carries one operation (push front, push back, pop front,
// pop back) and yields exactly one result transaction: the popped value (zero
// on a push or a failed pop), a status (ok, pop on empty, push on full), the
// element count afterwards and an empty flag. A failed push or pop leaves the
// queue unchanged. A transaction passes through capture, store access with
// registered read and result load; the load waits until the output register
// is free. A new transaction is accepted only once the last one is loaded;
// the result sits in an output register, so the next transaction is accepted
// while it waits to be taken. No clearing pass is needed after reset.
module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_func,
    input  logic [DATA_WIDTH-1:0]          i_value_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [DATA_WIDTH-1:0]          o_value_out,
    output logic [1:0]                     o_status,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic                           o_is_empty
);

    dq_pkg::t_dq_cmd cmd;
    dq_pkg::t_dq_sts sts;

    // sequencing of each transaction
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // store, pointers and result register
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

endmodule

@@ design/dq_ctrl.sv @@
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dq_pkg::t_dq_sts  i_sts,
    output dq_pkg::t_dq_cmd  o_cmd
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = dq_pkg::ST_LOAD;
            end
            dq_pkg::ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/dq_datapath.sv @@
module dq_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dq_pkg::t_dq_cmd                i_cmd,
    output dq_pkg::t_dq_sts                o_sts,
    input  logic [1:0]                     i_func,
    input  logic [DATA_WIDTH-1:0]          i_value_in,
    output logic                           o_valid,
    input  logic                           i_out_ready,
    output logic [DATA_WIDTH-1:0]          o_value_out,
    output logic [1:0]                     o_status,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic                           o_is_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // element store
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    // captured transaction
    dq_pkg::t_op           r_func;
    logic [DATA_WIDTH-1:0] r_value;

    // queue state
    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;

    // per-transaction working results
    logic [DATA_WIDTH-1:0] r_rd_data;
    dq_pkg::t_status       r_status, n_status;
    logic                  r_pop_ok, n_pop_ok;

    // output register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    dq_pkg::t_status       r_out_status;
    logic [CW-1:0]         r_out_count;
    logic                  r_out_empty;

    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic          full, empty;
    logic [PW-1:0] front_prev, front_next, back_prev, back_next;

    // pointer neighbours, wrapping at the store depth
    always_comb begin
        full       = (r_count == CW'(DEPTH));
        empty      = (r_count == '0);
        front_prev = (r_front == '0) ? PW'(DEPTH - 1) : r_front - 1'b1;
        front_next = (r_front == PW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        back_prev  = (r_back == '0) ? PW'(DEPTH - 1) : r_back - 1'b1;
        back_next  = (r_back == PW'(DEPTH - 1)) ? '0 : r_back + 1'b1;
    end

    // operation decode and state update
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = dq_pkg::STS_OK;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_back;
        rd_addr  = r_front;
        case (r_func)
            dq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = dq_pkg::STS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_prev;
                    n_front = front_prev;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = dq_pkg::STS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_back;
                    n_back  = back_next;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = dq_pkg::STS_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    rd_addr  = r_front;
                    n_front  = front_next;
                    n_count  = r_count - 1'b1;
                end
            end
            dq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = dq_pkg::STS_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    rd_addr  = back_prev;
                    n_back   = back_prev;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = dq_pkg::STS_OK;
            end
        endcase
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= dq_pkg::t_op'(i_func);
            r_value <= i_value_in;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // status of the executed transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_value  <= r_pop_ok ? r_rd_data : '0;
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_valid        = r_out_valid;
    assign o_value_out    = r_out_value;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;
    assign o_is_empty     = r_out_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond store depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_front == r_back))
        else $error("pointers apart on empty or full queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_count == $past(r_count)
                        || r_count == $past(r_count) + CW'(1)
                        || r_count == $past(r_count) - CW'(1)))
        else $error("count moved by more than one");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load))
        else $error("result shown without a load");
`endif

endmodule
